### hw/rtl/rfmd_pkg.sv
// shared types, constants and helpers of the radio-control frame mode decoder
`timescale 1ns / 1ps
package rfmd_pkg;

  // frame shape
  localparam int unsigned MaxChannels = 16;
  localparam int unsigned StickCount  = 4;
  localparam int unsigned CntW        = $clog2(MaxChannels + 1);
  localparam int unsigned SlotW       = $clog2(StickCount);

  // pulse constants in microseconds
  localparam logic [15:0] CentreUs  = 16'd1500;
  localparam logic [9:0]  SpanUs    = 10'd500;
  localparam logic [15:0] ModeMinUs = 16'd800;
  localparam logic [15:0] ModeMaxUs = 16'd2200;
  localparam logic [8:0]  DzMaxUs   = 9'd499;

  // stick scaling: q = (mag * 2^14 + div / 2) / div, 17 quotient bits
  localparam int unsigned QShift   = 14;
  localparam int unsigned NumW     = 16 + QShift + 1;
  localparam int unsigned QuotW    = 17;
  localparam int unsigned StepCntW = $clog2(QuotW);
  localparam logic signed [15:0] StickMax = 16'sh7fff;
  localparam logic signed [15:0] StickMin = 16'sh8000;

  // decoupling queue
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // configuration register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam logic [CfgIdxW-1:0] RegModeChan  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLandChan  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLowThr    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMidLowThr = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMidHiThr  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHighThr   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDeadZone  = 3'd6;

  typedef struct packed {
    logic [15:0] pulse_us;
    logic        frame_end;
  } in_t;

  typedef struct packed {
    logic signed [15:0] stick_0;
    logic signed [15:0] stick_1;
    logic signed [15:0] stick_2;
    logic signed [15:0] stick_3;
    logic               mode_ok;
    logic               manual_req;
    logic               takeoff_pos;
    logic               hover_pos;
    logic               command_pos;
    logic               hover_entered;
    logic               command_entered;
    logic               land_fired;
  } out_t;

  typedef struct packed {
    logic signed [4:0] mode_chan_index;
    logic signed [4:0] land_chan_index;
    logic [11:0]       low_thresh_us;
    logic [11:0]       mid_low_thresh_us;
    logic [11:0]       mid_high_thresh_us;
    logic [11:0]       high_thresh_us;
    logic [8:0]        dead_zone_us;
  } cfg_t;

  // one classified channel on its way from front to back
  typedef struct packed {
    logic [15:0]      pulse;
    logic             frame_end;
    logic             stick_en;
    logic [SlotW-1:0] slot;
    logic             mode_cap;
    logic             land_cap;
    logic [15:0]      mag;
    logic             neg;
    logic             dz_zero;
    logic             frame_ok;
    logic             mode_here;
    logic             land_here;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } back_state_e;

  // dead zone limited to one below the span
  function automatic logic [8:0] dz_clamp(input logic [8:0] dz);
    return (dz > DzMaxUs) ? DzMaxUs : dz;
  endfunction

endpackage

### hw/rtl/rfmd_front.sv
// front part: channel counting and classification of each incoming item
`timescale 1ns / 1ps
module rfmd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rfmd_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rfmd_pkg::in_t         in_data_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output rfmd_pkg::entry_t      entry_o
);

  logic [rfmd_pkg::CntW-1:0] chan_cnt_q, chan_cnt_d, cnt_next;
  logic                      in_range;
  logic [31:0]               cnt32, cnt_next32, mode_idx32, land_idx32;
  logic [8:0]                dz;
  logic [16:0]               pulse17, hi_edge, lo_sum, lo_edge, mag_hi, mag_lo;
  logic                      above, below;

  // handshake
  assign push_o     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  // channel position, saturating at the channel limit
  assign in_range   = chan_cnt_q < rfmd_pkg::CntW'(rfmd_pkg::MaxChannels);
  assign cnt_next   = in_range ? chan_cnt_q + 1'b1 : chan_cnt_q;
  assign cnt32      = 32'(chan_cnt_q);
  assign cnt_next32 = 32'(cnt_next);
  assign mode_idx32 = {28'd0, cfg_i.mode_chan_index[3:0]};
  assign land_idx32 = {28'd0, cfg_i.land_chan_index[3:0]};

  always_comb begin
    chan_cnt_d = chan_cnt_q;
    if (push_o) begin
      chan_cnt_d = in_data_i.frame_end ? '0 : cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= '0;
    end else begin
      chan_cnt_q <= chan_cnt_d;
    end
  end

  // dead zone test around the centre
  assign dz      = rfmd_pkg::dz_clamp(cfg_i.dead_zone_us);
  assign pulse17 = {1'b0, in_data_i.pulse_us};
  assign hi_edge = {1'b0, rfmd_pkg::CentreUs} + {8'd0, dz};
  assign lo_sum  = pulse17 + {8'd0, dz};
  assign lo_edge = {1'b0, rfmd_pkg::CentreUs} - {8'd0, dz};
  assign above   = pulse17 > hi_edge;
  assign below   = lo_sum < {1'b0, rfmd_pkg::CentreUs};
  assign mag_hi  = pulse17 - hi_edge;
  assign mag_lo  = lo_edge - pulse17;

  // classified item
  always_comb begin
    entry_o           = '0;
    entry_o.pulse     = in_data_i.pulse_us;
    entry_o.frame_end = in_data_i.frame_end;
    entry_o.stick_en  = in_range && (chan_cnt_q < rfmd_pkg::CntW'(rfmd_pkg::StickCount));
    entry_o.slot      = chan_cnt_q[rfmd_pkg::SlotW-1:0];
    entry_o.mode_cap  = in_range && !cfg_i.mode_chan_index[4] && (mode_idx32 == cnt32);
    entry_o.land_cap  = in_range && !cfg_i.land_chan_index[4] && (land_idx32 == cnt32);
    entry_o.mag       = above ? mag_hi[15:0] : (below ? mag_lo[15:0] : 16'd0);
    entry_o.neg       = below;
    entry_o.dz_zero   = !above && !below;
    entry_o.frame_ok  = cnt_next >= rfmd_pkg::CntW'(rfmd_pkg::StickCount);
    entry_o.mode_here = !cfg_i.mode_chan_index[4] && (mode_idx32 < cnt_next32);
    entry_o.land_here = !cfg_i.land_chan_index[4] && (land_idx32 < cnt_next32);
  end

endmodule

### hw/rtl/rfmd_queue.sv
// short queue of classified items between front and back
`timescale 1ns / 1ps
module rfmd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rfmd_pkg::entry_t      entry_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  logic                  pop_i,
  output rfmd_pkg::entry_t      entry_o
);

  rfmd_pkg::entry_t           mem_q [rfmd_pkg::QueueDepth];
  logic [rfmd_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [rfmd_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic                       do_push, do_pop;

  assign full_o  = cnt_q == rfmd_pkg::QCntW'(rfmd_pkg::QueueDepth);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == rfmd_pkg::QPtrW'(rfmd_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == rfmd_pkg::QPtrW'(rfmd_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rfmd_pkg::QCntW'(rfmd_pkg::QueueDepth))
    else $error("queue fill count beyond depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

### hw/rtl/rfmd_back.sv
// back part: stick scaling by iterative division, frame state and result register
`timescale 1ns / 1ps
module rfmd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rfmd_pkg::cfg_t        cfg_i,
  input  logic                  q_valid_i,
  input  rfmd_pkg::entry_t      q_entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rfmd_pkg::out_t        out_data_o
);

  rfmd_pkg::back_state_e         state_q, state_d;
  rfmd_pkg::entry_t              cur_q;
  logic signed [15:0]            stick_q [rfmd_pkg::StickCount];
  logic [15:0]                   frame_mode_q, frame_land_q, prev_mode_q, prev_land_q;
  logic                          mode_seen_q, land_seen_q;
  logic [8:0]                    rem_q, rem_d;
  logic [rfmd_pkg::QuotW-1:0]    num_q, num_d;
  logic [rfmd_pkg::StepCntW-1:0] step_q, step_d;
  logic                          out_valid_q, out_valid_d;
  rfmd_pkg::out_t                out_q;

  logic [8:0]                    divisor;
  logic [rfmd_pkg::NumW-1:0]     numer, div_top;
  logic                          sat;
  logic [9:0]                    trial;
  logic                          ge;
  logic                          last_step;
  logic                          stick_we;
  logic [rfmd_pkg::SlotW-1:0]    stick_slot;
  logic signed [15:0]            stick_wdata;
  logic                          div_start, emit;
  rfmd_pkg::out_t                res;
  logic                          upd_mode, upd_land;
  logic [15:0]                   m, l, pm, pl;
  logic                          hov, last_hov, cmd, last_cmd;

  // rounded quotient with sign and saturation
  function automatic logic signed [15:0] stick_round(input logic [rfmd_pkg::QuotW-1:0] q,
                                                     input logic neg);
    logic [rfmd_pkg::QuotW-1:0] nq;
    nq = ~q + 1'b1;
    if (!neg) begin
      return (q > 17'd32767) ? rfmd_pkg::StickMax : signed'(q[15:0]);
    end
    return (q > 17'd32768) ? rfmd_pkg::StickMin : signed'(nq[15:0]);
  endfunction

  function automatic logic in_hover(input logic [15:0] p, input rfmd_pkg::cfg_t c);
    return (p >= {4'd0, c.mid_low_thresh_us}) && (p <= {4'd0, c.mid_high_thresh_us});
  endfunction

  // divisor and scaled numerator of the dispatched item
  assign divisor = 9'(rfmd_pkg::SpanUs - {1'b0, rfmd_pkg::dz_clamp(cfg_i.dead_zone_us)});
  assign numer   = {1'b0, q_entry_i.mag, {rfmd_pkg::QShift{1'b0}}}
                 + {23'd0, divisor[8:1]};
  assign div_top = {5'd0, divisor, {rfmd_pkg::QuotW{1'b0}}};
  assign sat     = numer >= div_top;

  // one restoring division step
  assign trial     = {rem_q, num_q[rfmd_pkg::QuotW-1]};
  assign ge        = trial >= {1'b0, divisor};
  assign last_step = step_q == rfmd_pkg::StepCntW'(rfmd_pkg::QuotW - 1);

  assign pop_o = (state_q == rfmd_pkg::S_IDLE) && q_valid_i;
  assign emit  = (state_q == rfmd_pkg::S_EMIT) && (!out_valid_q || !out_stall_i);

  // dispatch, division and emit control
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    num_d       = num_q;
    step_d      = step_q;
    stick_we    = 1'b0;
    stick_slot  = cur_q.slot;
    stick_wdata = '0;
    div_start   = 1'b0;
    case (state_q)
      rfmd_pkg::S_IDLE: begin
        if (q_valid_i) begin
          stick_slot = q_entry_i.slot;
          if (q_entry_i.stick_en && !q_entry_i.dz_zero && !sat) begin
            div_start = 1'b1;
            rem_d     = numer[rfmd_pkg::QuotW +: 9];
            num_d     = numer[rfmd_pkg::QuotW-1:0];
            step_d    = '0;
          end else if (q_entry_i.stick_en) begin
            stick_we    = 1'b1;
            stick_wdata = q_entry_i.dz_zero ? 16'sd0
                        : (q_entry_i.neg ? rfmd_pkg::StickMin : rfmd_pkg::StickMax);
          end
          if (div_start) begin
            state_d = rfmd_pkg::S_DIV;
          end else if (q_entry_i.frame_end) begin
            state_d = rfmd_pkg::S_EMIT;
          end
        end
      end
      rfmd_pkg::S_DIV: begin
        rem_d  = ge ? 9'(trial - {1'b0, divisor}) : trial[8:0];
        num_d  = {num_q[rfmd_pkg::QuotW-2:0], ge};
        step_d = step_q + 1'b1;
        if (last_step) begin
          stick_we    = 1'b1;
          stick_wdata = stick_round(num_d, cur_q.neg);
          state_d     = cur_q.frame_end ? rfmd_pkg::S_EMIT : rfmd_pkg::S_IDLE;
        end
      end
      rfmd_pkg::S_EMIT: begin
        if (emit) begin
          state_d = rfmd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rfmd_pkg::S_IDLE;
      end
    endcase
  end

  // result of a closed frame
  assign m        = frame_mode_q;
  assign l        = frame_land_q;
  assign pm       = mode_seen_q ? prev_mode_q : m;
  assign pl       = land_seen_q ? prev_land_q : l;
  assign hov      = in_hover(m, cfg_i);
  assign last_hov = in_hover(pm, cfg_i);
  assign cmd      = m > {4'd0, cfg_i.high_thresh_us};
  assign last_cmd = pm > {4'd0, cfg_i.high_thresh_us};

  always_comb begin
    res            = '0;
    res.manual_req = 1'b1;
    upd_mode       = 1'b0;
    upd_land       = 1'b0;
    if (cur_q.frame_ok) begin
      res.stick_0 = stick_q[0];
      res.stick_1 = stick_q[1];
      res.stick_2 = stick_q[2];
      res.stick_3 = stick_q[3];
      if (cur_q.mode_here) begin
        upd_mode = 1'b1;
        if ((m >= rfmd_pkg::ModeMinUs) && (m <= rfmd_pkg::ModeMaxUs)) begin
          res.mode_ok         = 1'b1;
          res.manual_req      = 1'b0;
          res.takeoff_pos     = m < {4'd0, cfg_i.low_thresh_us};
          res.hover_pos       = hov;
          res.command_pos     = cmd;
          res.hover_entered   = !last_hov && hov;
          res.command_entered = !last_cmd && cmd;
          if (cur_q.land_here) begin
            upd_land       = 1'b1;
            res.land_fired = (pl < {4'd0, cfg_i.low_thresh_us})
                          && (l > {4'd0, cfg_i.high_thresh_us});
          end
        end
      end
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rfmd_pkg::S_IDLE;
      out_valid_q  <= 1'b0;
      frame_mode_q <= '0;
      frame_land_q <= '0;
      prev_mode_q  <= '0;
      prev_land_q  <= '0;
      mode_seen_q  <= 1'b0;
      land_seen_q  <= 1'b0;
      for (int i = 0; i < rfmd_pkg::StickCount; i++) begin
        stick_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (pop_o && q_entry_i.mode_cap) begin
        frame_mode_q <= q_entry_i.pulse;
      end
      if (pop_o && q_entry_i.land_cap) begin
        frame_land_q <= q_entry_i.pulse;
      end
      if (stick_we) begin
        stick_q[stick_slot] <= stick_wdata;
      end
      if (emit && upd_mode) begin
        prev_mode_q <= m;
        mode_seen_q <= 1'b1;
      end
      if (emit && upd_land) begin
        prev_land_q <= l;
        land_seen_q <= 1'b1;
      end
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_entry_i;
    end
    rem_q  <= rem_d;
    num_q  <= num_d;
    step_q <= step_d;
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rfmd_pkg::S_DIV && !last_step) |=> state_q == rfmd_pkg::S_DIV)
    else $error("division left before its last step");
  a_emit_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rfmd_pkg::S_EMIT |-> cur_q.frame_end)
    else $error("result pending without a frame end item");
  a_manual_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.manual_req != out_q.mode_ok)
    else $error("manual request and mode ok disagree");
  a_entry_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.hover_entered || out_q.hover_pos)
                 && (!out_q.command_entered || out_q.command_pos))
    else $error("entry edge without position");
`endif

endmodule

### hw/rtl/rc_frame_mode_decoder_top.sv
// top level of the radio-control frame mode decoder: configuration registers and wiring
`timescale 1ns / 1ps
// Usage:
//   Input channel: one item per channel pulse (pulse_us, frame_end) on in_valid_i /
//   in_stall_o / in_data_i. The item with frame_end set closes the frame and causes
//   one result on out_valid_o / out_stall_i / out_data_o; other items cause none.
//   Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i at the clock edge.
//   Write registers only while no frame work is pending (not enforced by the block).
// Flow:
//   The front classifies each item combinationally and places it in a two-entry queue.
//   The back dispatches one item per cycle while idle; a stick channel outside the dead
//   zone and below saturation holds it while the restoring divider works out the
//   quotient, and the back takes the next item only after the last division step.
//   A frame end item then moves the back to its emit state, which registers the
//   result; while a valid result is stalled at the output, the emit state waits.
// Reset: all frame and history state clears, registers take their reset values.
// Stall: a stalled result holds in the output register; the back waits, the queue
//   fills and then in_stall_o rises.
module rc_frame_mode_decoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rfmd_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rfmd_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [rfmd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rfmd_pkg::CfgDataW-1:0]  cfg_data_i
);

  rfmd_pkg::cfg_t   cfg_q;
  rfmd_pkg::entry_t front_entry, queue_entry;
  logic             push, q_full, q_valid, pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_chan_index    <= 5'sd7;
      cfg_q.land_chan_index    <= 5'sd9;
      cfg_q.low_thresh_us      <= 12'd1200;
      cfg_q.mid_low_thresh_us  <= 12'd1400;
      cfg_q.mid_high_thresh_us <= 12'd1600;
      cfg_q.high_thresh_us     <= 12'd1800;
      cfg_q.dead_zone_us       <= 9'd50;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rfmd_pkg::RegModeChan:  cfg_q.mode_chan_index    <= signed'(cfg_data_i[4:0]);
        rfmd_pkg::RegLandChan:  cfg_q.land_chan_index    <= signed'(cfg_data_i[4:0]);
        rfmd_pkg::RegLowThr:    cfg_q.low_thresh_us      <= cfg_data_i;
        rfmd_pkg::RegMidLowThr: cfg_q.mid_low_thresh_us  <= cfg_data_i;
        rfmd_pkg::RegMidHiThr:  cfg_q.mid_high_thresh_us <= cfg_data_i;
        rfmd_pkg::RegHighThr:   cfg_q.high_thresh_us     <= cfg_data_i;
        rfmd_pkg::RegDeadZone:  cfg_q.dead_zone_us       <= cfg_data_i[8:0];
        default: begin
        end
      endcase
    end
  end

  // item classification
  rfmd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (front_entry)
  );

  // decoupling queue
  rfmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (queue_entry)
  );

  // scaling and result
  rfmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (queue_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
